// File: hw/rtl/agt_pkg.sv
`timescale 1ns / 1ps

package agt_pkg;

    // field widths fixed by the interface
    localparam int NODE_W = 6;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 11;
    localparam int ACT_W  = 3;

    // widest matrix address, for the largest node count
    localparam int ADDR_MAX_W = 2 * NODE_W;

    // edge count saturates here
    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

    // neighbor scan result cap and the width of its counter
    localparam int MAX_RESULTS = 32;
    localparam int NF_W        = 6;

    // command queue depth between front and back
    localparam int QDEPTH = 2;

    // marker value after reset
    localparam logic [VAL_W-1:0] RESET_MARKER = 16'hFFFF;

    // action codes
    typedef enum logic [ACT_W-1:0] {
        OP_ADD  = 3'd0,
        OP_DEL  = 3'd1,
        OP_ADJ  = 3'd2,
        OP_NBR  = 3'd3,
        OP_RD   = 3'd4,
        OP_WR   = 3'd5,
        OP_CLR  = 3'd6,
        OP_NONE = 3'd7
    } t_op;

    // classified command handed from front to back
    typedef struct packed {
        t_op               op;
        logic [NODE_W-1:0] x;
        logic [NODE_W-1:0] y;
        logic [VAL_W-1:0]  val;
        logic              inr;
        logic              xin;
        logic              diag;
    } t_cmd;

    // one result word
    typedef struct packed {
        logic              ok;
        logic              adj;
        logic              found;
        logic [NODE_W-1:0] idx;
        logic [VAL_W-1:0]  val;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_result;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // back end status
    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage

// File: hw/rtl/agt_front.sv
`timescale 1ns / 1ps

module agt_front #(
    parameter int NODES = 32
) (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [agt_pkg::ACT_W-1:0]   i_action,
    input  logic [agt_pkg::NODE_W-1:0]  i_node_x,
    input  logic [agt_pkg::NODE_W-1:0]  i_node_y,
    input  logic [agt_pkg::VAL_W-1:0]   i_edge_value,
    input  agt_pkg::t_q_stat            i_q_stat,
    input  agt_pkg::t_back_stat         i_bstat,
    output logic                        o_push,
    output agt_pkg::t_cmd               o_cmd
);

    logic xin;
    logic yin;

    // range checks against the node count
    assign xin = ({1'b0, i_node_x} < (agt_pkg::NODE_W + 1)'(NODES));
    assign yin = ({1'b0, i_node_y} < (agt_pkg::NODE_W + 1)'(NODES));

    // take a word whenever the queue has room and the matrix is initialized
    assign o_ready = !i_q_stat.full && !i_bstat.init_busy;
    assign o_push  = i_valid && o_ready;

    // classify the word
    always_comb begin
        o_cmd.op   = agt_pkg::t_op'(i_action);
        o_cmd.x    = i_node_x;
        o_cmd.y    = i_node_y;
        o_cmd.val  = i_edge_value;
        o_cmd.xin  = xin;
        o_cmd.inr  = xin && yin;
        o_cmd.diag = (i_node_x == i_node_y);
    end

endmodule

// File: hw/rtl/agt_fifo.sv
`timescale 1ns / 1ps

module agt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  agt_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output agt_pkg::t_cmd     o_cmd,
    output agt_pkg::t_q_stat  o_stat
);

    localparam int PW = (agt_pkg::QDEPTH > 1) ? $clog2(agt_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(agt_pkg::QDEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(agt_pkg::QDEPTH - 1);

    agt_pkg::t_cmd   r_buf [agt_pkg::QDEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

    assign o_cmd        = r_buf[r_rd];
    assign o_stat.full  = (r_cnt == CW'(agt_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// File: hw/rtl/agt_back.sv
`timescale 1ns / 1ps

module agt_back #(
    parameter int NODES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  agt_pkg::t_cmd              i_cmd,
    input  agt_pkg::t_q_stat           i_q_stat,
    output logic                       o_pop,
    input  logic                       i_cfg_we,
    input  logic [agt_pkg::VAL_W-1:0]  i_cfg_data,
    output agt_pkg::t_back_stat        o_bstat,
    output logic                       o_valid,
    input  logic                       i_ready,
    output agt_pkg::t_result           o_res
);

    localparam int DEPTH = NODES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(NODES);
    localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);
    localparam logic [agt_pkg::NF_W-1:0] NF_CAP = agt_pkg::NF_W'(agt_pkg::MAX_RESULTS);

    typedef enum logic [7:0] {
        S_FILL   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EVAL   = 8'b0000_0100,
        S_MIRROR = 8'b0000_1000,
        S_EMIT   = 8'b0001_0000,
        S_NREAD  = 8'b0010_0000,
        S_NCHK   = 8'b0100_0000,
        S_NEND   = 8'b1000_0000
    } t_state;

    // row-major matrix address
    function automatic logic [AW-1:0] f_addr(input logic [agt_pkg::NODE_W-1:0] row,
                                             input logic [agt_pkg::NODE_W-1:0] col);
        logic [agt_pkg::ADDR_MAX_W-1:0] t;
        t = agt_pkg::ADDR_MAX_W'(row) * agt_pkg::ADDR_MAX_W'(NODES)
            + agt_pkg::ADDR_MAX_W'(col);
        return t[AW-1:0];
    endfunction

    logic [agt_pkg::VAL_W-1:0]  r_mem [DEPTH];
    logic [agt_pkg::VAL_W-1:0]  r_rdata;

    t_state                     r_state,      n_state;
    agt_pkg::t_cmd              r_cmd,        n_cmd;
    logic [agt_pkg::VAL_W-1:0]  r_marker;
    logic [agt_pkg::CNT_W-1:0]  r_total,      n_total;
    logic [agt_pkg::VAL_W-1:0]  r_fill_val,   n_fill_val;
    logic                       r_fill_reset, n_fill_reset;
    logic [IW-1:0]              r_row,        n_row;
    logic [IW-1:0]              r_col,        n_col;
    logic                       r_pend,       n_pend;
    logic [IW-1:0]              r_pend_idx,   n_pend_idx;
    logic [agt_pkg::NF_W-1:0]   r_nfound,     n_nfound;
    agt_pkg::t_result           r_res,        n_res;
    logic                       r_ovalid,     n_ovalid;
    agt_pkg::t_result           r_out,        n_out;

    logic                       mem_we;
    logic [AW-1:0]              waddr;
    logic [agt_pkg::VAL_W-1:0]  wdata;
    logic                       mem_re;
    logic [AW-1:0]              raddr;
    logic                       load;
    agt_pkg::t_result           load_res;
    logic                       slot_free;
    logic                       hit;
    logic                       col_last;
    logic                       row_last;
    logic [agt_pkg::NF_W-1:0]   nf_inc;
    logic [AW-1:0]              addr_xy;
    logic [AW-1:0]              addr_yx;

    assign slot_free = !r_ovalid || i_ready;
    assign col_last  = (r_col == LAST_IDX);
    assign row_last  = (r_row == LAST_IDX);
    assign nf_inc    = r_nfound + 1'b1;
    assign hit       = (agt_pkg::NODE_W'(r_col) != r_cmd.x) && (r_rdata != r_marker);
    assign addr_xy   = f_addr(r_cmd.x, r_cmd.y);
    assign addr_yx   = f_addr(r_cmd.y, r_cmd.x);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_total      = r_total;
        n_fill_val   = r_fill_val;
        n_fill_reset = r_fill_reset;
        n_row        = r_row;
        n_col        = r_col;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_nfound     = r_nfound;
        n_res        = r_res;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        waddr        = '0;
        wdata        = '0;
        mem_re       = 1'b0;
        raddr        = '0;
        load         = 1'b0;
        load_res     = '0;

        case (r_state)
            // write one entry a cycle, diagonal zero
            S_FILL: begin
                mem_we = 1'b1;
                waddr  = f_addr(agt_pkg::NODE_W'(r_row), agt_pkg::NODE_W'(r_col));
                wdata  = (r_row == r_col) ? '0 : r_fill_val;
                n_col  = r_col + 1'b1;
                if (col_last) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                    if (row_last) begin
                        n_row        = '0;
                        n_fill_reset = 1'b0;
                        n_res        = '0;
                        n_res.ok     = 1'b1;
                        n_res.last   = 1'b1;
                        n_state      = r_fill_reset ? S_IDLE : S_EMIT;
                    end
                end
            end

            // take the next command and read its entry
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    mem_re  = 1'b1;
                    raddr   = i_cmd.inr ? f_addr(i_cmd.x, i_cmd.y) : '0;
                    n_state = S_EVAL;
                end
            end

            // decide on the entry, first write
            S_EVAL: begin
                n_res      = '0;
                n_res.last = 1'b1;
                n_state    = S_EMIT;
                case (r_cmd.op)
                    agt_pkg::OP_ADD: begin
                        if (r_cmd.inr && !r_cmd.diag && r_rdata == r_marker) begin
                            mem_we   = 1'b1;
                            waddr    = addr_xy;
                            wdata    = r_cmd.val;
                            n_res.ok = 1'b1;
                            if (r_total != agt_pkg::CNT_MAX) begin
                                n_total = r_total + 1'b1;
                            end
                            n_state = S_MIRROR;
                        end
                    end
                    agt_pkg::OP_DEL: begin
                        if (r_cmd.inr && !r_cmd.diag && r_rdata != r_marker) begin
                            mem_we   = 1'b1;
                            waddr    = addr_xy;
                            wdata    = r_marker;
                            n_res.ok = 1'b1;
                            if (r_total != '0) begin
                                n_total = r_total - 1'b1;
                            end
                            n_state = S_MIRROR;
                        end
                    end
                    agt_pkg::OP_ADJ: begin
                        n_res.ok  = r_cmd.inr;
                        n_res.adj = r_cmd.inr && (r_rdata != r_marker);
                    end
                    agt_pkg::OP_NBR: begin
                        if (r_cmd.xin) begin
                            n_col    = '0;
                            n_pend   = 1'b0;
                            n_nfound = '0;
                            n_state  = S_NREAD;
                        end
                    end
                    agt_pkg::OP_RD: begin
                        n_res.ok  = r_cmd.inr;
                        n_res.val = r_cmd.inr ? r_rdata : '0;
                    end
                    agt_pkg::OP_WR: begin
                        if (r_cmd.inr) begin
                            mem_we   = 1'b1;
                            waddr    = addr_xy;
                            wdata    = r_cmd.val;
                            n_res.ok = 1'b1;
                            n_state  = S_MIRROR;
                        end
                    end
                    agt_pkg::OP_CLR: begin
                        n_total      = '0;
                        n_fill_val   = r_marker;
                        n_fill_reset = 1'b0;
                        n_row        = '0;
                        n_col        = '0;
                        n_state      = S_FILL;
                    end
                    default: begin
                        n_res.ok = 1'b0;
                    end
                endcase
            end

            // mirror entry
            S_MIRROR: begin
                mem_we  = 1'b1;
                waddr   = addr_yx;
                wdata   = (r_cmd.op == agt_pkg::OP_DEL) ? r_marker : r_cmd.val;
                n_state = S_EMIT;
            end

            // hand the single result to the output register
            S_EMIT: begin
                if (slot_free) begin
                    load     = 1'b1;
                    load_res = r_res;
                    n_state  = S_IDLE;
                end
            end

            // read one column of the row
            S_NREAD: begin
                mem_re  = 1'b1;
                raddr   = f_addr(r_cmd.x, agt_pkg::NODE_W'(r_col));
                n_state = S_NCHK;
            end

            // one neighbor is held back so the final one can carry last
            S_NCHK: begin
                if (hit) begin
                    if (!r_pend || slot_free) begin
                        if (r_pend) begin
                            load           = 1'b1;
                            load_res.ok    = 1'b1;
                            load_res.found = 1'b1;
                            load_res.idx   = agt_pkg::NODE_W'(r_pend_idx);
                        end
                        n_pend     = 1'b1;
                        n_pend_idx = r_col;
                        n_nfound   = nf_inc;
                        if (nf_inc == NF_CAP || col_last) begin
                            n_state = S_NEND;
                        end else begin
                            n_col   = r_col + 1'b1;
                            n_state = S_NREAD;
                        end
                    end
                end else if (col_last) begin
                    n_state = S_NEND;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_state = S_NREAD;
                end
            end

            // final scan result, or the empty one
            S_NEND: begin
                if (slot_free) begin
                    load           = 1'b1;
                    load_res.ok    = 1'b1;
                    load_res.found = r_pend;
                    load_res.idx   = r_pend ? agt_pkg::NODE_W'(r_pend_idx) : '0;
                    load_res.last  = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_ovalid = r_ovalid;
        n_out    = r_out;
        if (load) begin
            n_ovalid    = 1'b1;
            n_out       = load_res;
            n_out.count = r_total;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_fill_reset <= 1'b1;
            r_fill_val   <= agt_pkg::RESET_MARKER;
            r_marker     <= agt_pkg::RESET_MARKER;
            r_total      <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_pend       <= 1'b0;
            r_nfound     <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill_reset <= n_fill_reset;
            r_fill_val   <= n_fill_val;
            r_total      <= n_total;
            r_row        <= n_row;
            r_col        <= n_col;
            r_pend       <= n_pend;
            r_nfound     <= n_nfound;
            r_ovalid     <= n_ovalid;
            if (i_cfg_we) begin
                r_marker <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // edge matrix, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    assign o_bstat.init_busy = (r_state == S_FILL) && r_fill_reset;
    assign o_valid           = r_ovalid;
    assign o_res             = r_out;

endmodule

// File: hw/rtl/adjacency_matrix_graph_table.sv
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// command   in         i_valid / o_ready   i_action, i_node_x, i_node_y, i_edge_value
// result    out        o_valid / i_ready   o_ok, o_is_adjacent, o_neighbor_found,
//                                          o_neighbor_index, o_edge_value_out,
//                                          o_edge_count, o_last
// marker    in         i_cfg_we            i_cfg_data
//
// a successful add or delete and an in-range write go through pop with read, decide with
// first write, mirror write and output load; other one-word actions skip the mirror write,
// which the single write port of the edge matrix makes a step of its own. a neighbor scan
// reads and checks each node of the row and waits on output stalls. clear and the pass after
// reset write one entry a cycle; no command is taken during the reset pass. a two-entry
// command queue and the output register let the front take words while a result waits.

module adjacency_matrix_graph_table #(
    parameter int NODES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [agt_pkg::ACT_W-1:0]   i_action,
    input  logic [agt_pkg::NODE_W-1:0]  i_node_x,
    input  logic [agt_pkg::NODE_W-1:0]  i_node_y,
    input  logic [agt_pkg::VAL_W-1:0]   i_edge_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_ok,
    output logic                        o_is_adjacent,
    output logic                        o_neighbor_found,
    output logic [agt_pkg::NODE_W-1:0]  o_neighbor_index,
    output logic [agt_pkg::VAL_W-1:0]   o_edge_value_out,
    output logic [agt_pkg::CNT_W-1:0]   o_edge_count,
    output logic                        o_last,
    input  logic                        i_cfg_we,
    input  logic [agt_pkg::VAL_W-1:0]   i_cfg_data
);

    agt_pkg::t_cmd        push_cmd;
    agt_pkg::t_cmd        head_cmd;
    agt_pkg::t_q_stat     q_stat;
    agt_pkg::t_back_stat  bstat;
    agt_pkg::t_result     res;
    logic                 q_push;
    logic                 q_pop;

    // accept and classify
    agt_front #(
        .NODES (NODES)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_node_x     (i_node_x),
        .i_node_y     (i_node_y),
        .i_edge_value (i_edge_value),
        .i_q_stat     (q_stat),
        .i_bstat      (bstat),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    // command queue
    agt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // matrix, sequencer and output register
    agt_back #(
        .NODES (NODES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_q_stat   (q_stat),
        .o_pop      (q_pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_bstat    (bstat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (res)
    );

    // result word to ports
    assign o_ok             = res.ok;
    assign o_is_adjacent    = res.adj;
    assign o_neighbor_found = res.found;
    assign o_neighbor_index = res.idx;
    assign o_edge_value_out = res.val;
    assign o_edge_count     = res.count;
    assign o_last           = res.last;

    // queue never overflows or underflows
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    // a neighbor word carries nothing of the other actions
    a_nbr_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_neighbor_found) |-> (o_ok && !o_is_adjacent && o_edge_value_out == '0))
        else $error("neighbor word mixed with other fields");

    // no result while the matrix is being initialized
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.init_busy |-> (!o_valid && !o_ready))
        else $error("activity during reset pass");

endmodule
